// ===== src/scfl_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the size-class allocator.
`default_nettype none
package scfl_pkg;

  localparam int MemUnits       = 65536;
  localparam int ChunkUnits     = 8192;
  localparam int MaxObjectBytes = 4096;
  localparam int RefillBlocks   = 10;

  localparam int NumClasses = MaxObjectBytes / 8;
  localparam int ClsW       = $clog2(NumClasses);
  localparam int BlkW       = ClsW + 1;
  localparam int AddrW      = 17;
  localparam int SizeW      = 16;
  localparam int LinkAw     = $clog2(MemUnits);
  localparam int CntW       = $clog2(RefillBlocks + 1);
  localparam int PoolLimit  = MemUnits + 1;
  localparam int EndInit    = (1 + ChunkUnits > PoolLimit) ? PoolLimit : 1 + ChunkUnits;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_MEMORY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_HEAD,
    SRC_CURSOR
  } res_src_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BAD,
    S_FREE_RD,
    S_FREE_WR,
    S_ALLOC_RD,
    S_ALLOC_HD,
    S_POP,
    S_REFILL,
    S_REM_WR,
    S_CHUNK,
    S_CARVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     ready;
    logic     latch;
    logic     clr;
    logic     free_rd;
    logic     free_wr;
    logic     alloc_hd;
    logic     pop;
    logic     rem_rd;
    logic     rem_wr;
    logic     next_chunk;
    logic     carve;
    logic     carve_end;
    logic     set_res;
    status_e  res_code;
    res_src_e res_src;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic    clr_last;
    logic    realloc;
    logic    free_bad;
    status_e free_code;
    logic    size_bad;
    status_e size_code;
    logic    head_zero;
    logic    rem_ge_b;
    logic    rem_nz;
    logic    carve_last;
    logic    pool_out;
    logic    out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/scfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/scfl_ctrl.sv =====
// Request sequencer: clearing pass, free/alloc/refill steps and result handoff.
`default_nettype none
module scfl_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [1:0]   in_mode_i,
  input  wire scfl_pkg::sts_t sts_i,
  output scfl_pkg::cmd_t    cmd_o
);

  scfl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scfl_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scfl_pkg::S_CLEAR: if (sts_i.clr_last) state_d = scfl_pkg::S_IDLE;
      scfl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            scfl_pkg::MODE_ALLOC:   state_d = scfl_pkg::S_ALLOC_RD;
            scfl_pkg::MODE_FREE:    state_d = scfl_pkg::S_FREE_RD;
            scfl_pkg::MODE_REALLOC: state_d = scfl_pkg::S_FREE_RD;
            default:                state_d = scfl_pkg::S_BAD;
          endcase
        end
      end
      scfl_pkg::S_BAD: state_d = scfl_pkg::S_DONE;
      scfl_pkg::S_FREE_RD: begin
        if (!sts_i.free_bad) state_d = scfl_pkg::S_FREE_WR;
        else if (sts_i.realloc) state_d = scfl_pkg::S_ALLOC_RD;
        else state_d = scfl_pkg::S_DONE;
      end
      scfl_pkg::S_FREE_WR:
        state_d = sts_i.realloc ? scfl_pkg::S_ALLOC_RD : scfl_pkg::S_DONE;
      scfl_pkg::S_ALLOC_RD:
        state_d = sts_i.size_bad ? scfl_pkg::S_DONE : scfl_pkg::S_ALLOC_HD;
      scfl_pkg::S_ALLOC_HD:
        state_d = sts_i.head_zero ? scfl_pkg::S_REFILL : scfl_pkg::S_POP;
      scfl_pkg::S_POP: state_d = scfl_pkg::S_DONE;
      scfl_pkg::S_REFILL: begin
        if (sts_i.rem_ge_b) state_d = scfl_pkg::S_CARVE;
        else if (sts_i.rem_nz) state_d = scfl_pkg::S_REM_WR;
        else state_d = scfl_pkg::S_CHUNK;
      end
      scfl_pkg::S_REM_WR: state_d = scfl_pkg::S_CHUNK;
      scfl_pkg::S_CHUNK:
        state_d = sts_i.pool_out ? scfl_pkg::S_DONE : scfl_pkg::S_REFILL;
      scfl_pkg::S_CARVE: if (sts_i.carve_last) state_d = scfl_pkg::S_DONE;
      scfl_pkg::S_DONE: if (sts_i.out_free) state_d = scfl_pkg::S_IDLE;
      default: state_d = scfl_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_code = scfl_pkg::ST_OK;
    cmd_o.res_src  = scfl_pkg::SRC_NONE;
    case (state_q)
      scfl_pkg::S_CLEAR: cmd_o.clr = 1'b1;
      scfl_pkg::S_IDLE: begin
        cmd_o.ready = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      scfl_pkg::S_BAD: begin
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = scfl_pkg::ST_INVALID;
      end
      scfl_pkg::S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        if (sts_i.free_bad && !sts_i.realloc) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = sts_i.free_code;
        end
      end
      scfl_pkg::S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        cmd_o.set_res = !sts_i.realloc;
      end
      scfl_pkg::S_ALLOC_RD: begin
        if (sts_i.size_bad) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = sts_i.size_code;
        end
      end
      scfl_pkg::S_ALLOC_HD: cmd_o.alloc_hd = 1'b1;
      scfl_pkg::S_POP: begin
        cmd_o.pop     = 1'b1;
        cmd_o.set_res = 1'b1;
        cmd_o.res_src = scfl_pkg::SRC_HEAD;
      end
      scfl_pkg::S_REFILL: cmd_o.rem_rd = !sts_i.rem_ge_b;
      scfl_pkg::S_REM_WR: cmd_o.rem_wr = 1'b1;
      scfl_pkg::S_CHUNK: begin
        cmd_o.next_chunk = 1'b1;
        if (sts_i.pool_out) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = scfl_pkg::ST_NO_MEMORY;
        end
      end
      scfl_pkg::S_CARVE: begin
        cmd_o.carve = 1'b1;
        if (sts_i.carve_last) begin
          cmd_o.carve_end = 1'b1;
          cmd_o.set_res   = 1'b1;
          cmd_o.res_src   = scfl_pkg::SRC_CURSOR;
        end
      end
      scfl_pkg::S_DONE: cmd_o.out_load = sts_i.out_free;
      default: cmd_o.clr = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/scfl_dp.sv =====
// Datapath: request registers, class head and link memories, bump cursor, result register.
`default_nettype none
module scfl_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire scfl_pkg::cmd_t              cmd_i,
  output scfl_pkg::sts_t                   sts_o,
  input  wire logic [1:0]                  in_mode_i,
  input  wire logic [scfl_pkg::SizeW-1:0]  in_size_i,
  input  wire logic [scfl_pkg::SizeW-1:0]  in_prev_size_i,
  input  wire logic [scfl_pkg::AddrW-1:0]  in_address_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       out_status_o,
  output logic [scfl_pkg::AddrW-1:0]       out_block_o
);

  localparam int AW = scfl_pkg::AddrW;
  localparam int CW = scfl_pkg::ClsW;

  logic [1:0]                  mode_q;
  logic [scfl_pkg::SizeW-1:0]  size_q, prev_size_q;
  logic [AW-1:0]               addr_q;
  logic [AW-1:0]               cur_q, cur_d, end_q, end_d;
  logic [AW-1:0]               hd_q;
  logic [scfl_pkg::CntW-1:0]   cnt_q;
  logic [CW-1:0]               clr_idx_q;
  logic [1:0]                  res_st_q;
  logic [AW-1:0]               res_blk_q;
  logic                        out_valid_q;
  logic [1:0]                  out_st_q;
  logic [AW-1:0]               out_blk_q;

  logic                        realloc;
  logic [scfl_pkg::SizeW-1:0]  fsize;
  logic [scfl_pkg::SizeW:0]    fs7, as7;
  logic [CW-1:0]               fcls, acls, rem_cls;
  logic [scfl_pkg::BlkW-1:0]   blk;
  logic [AW-1:0]               blk_z, rem, rem_after;
  logic [AW:0]                 nsum;

  logic          h_we;
  logic [CW-1:0] h_waddr, h_raddr;
  logic [AW-1:0] h_wdata, h_rdata;
  logic          l_we;
  logic [scfl_pkg::LinkAw-1:0] l_waddr, l_raddr;
  logic [AW-1:0] l_wdata, l_rdata;

  assign realloc = (mode_q == scfl_pkg::MODE_REALLOC);
  assign fsize   = realloc ? prev_size_q : size_q;
  assign fs7     = {1'b0, fsize} + (scfl_pkg::SizeW+1)'(7);
  assign as7     = {1'b0, size_q} + (scfl_pkg::SizeW+1)'(7);
  // class = ceil(bytes/8) - 1
  assign fcls    = CW'((fs7 >> 3) - (scfl_pkg::SizeW+1)'(1));
  assign acls    = CW'((as7 >> 3) - (scfl_pkg::SizeW+1)'(1));
  assign blk     = {1'b0, acls} + scfl_pkg::BlkW'(1);
  assign blk_z   = AW'(blk);
  assign rem     = (end_q > cur_q) ? end_q - cur_q : '0;
  assign rem_after = rem - blk_z;
  assign rem_cls = CW'(rem - AW'(1));
  assign nsum    = {1'b0, end_q} + (AW+1)'(scfl_pkg::ChunkUnits);

  always_comb begin
    sts_o = '0;
    sts_o.clr_last = (clr_idx_q == CW'(scfl_pkg::NumClasses - 1));
    sts_o.realloc  = realloc;
    sts_o.free_code = scfl_pkg::ST_OK;
    if (addr_q == '0 || fsize == '0) begin
      sts_o.free_bad  = 1'b1;
      sts_o.free_code = scfl_pkg::ST_INVALID;
    end else if (fsize > scfl_pkg::SizeW'(scfl_pkg::MaxObjectBytes)) begin
      sts_o.free_bad  = 1'b1;
      sts_o.free_code = scfl_pkg::ST_TOO_LARGE;
    end else if (addr_q > AW'(scfl_pkg::MemUnits)) begin
      sts_o.free_bad  = 1'b1;
      sts_o.free_code = scfl_pkg::ST_INVALID;
    end
    sts_o.size_code = scfl_pkg::ST_OK;
    if (size_q == '0) begin
      sts_o.size_bad  = 1'b1;
      sts_o.size_code = scfl_pkg::ST_INVALID;
    end else if (size_q > scfl_pkg::SizeW'(scfl_pkg::MaxObjectBytes)) begin
      sts_o.size_bad  = 1'b1;
      sts_o.size_code = scfl_pkg::ST_TOO_LARGE;
    end
    sts_o.head_zero  = (h_rdata == '0);
    sts_o.rem_ge_b   = (rem >= blk_z);
    sts_o.rem_nz     = (rem != '0);
    sts_o.carve_last = (cnt_q == scfl_pkg::CntW'(scfl_pkg::RefillBlocks - 1)) ||
                       (rem_after < blk_z);
    sts_o.pool_out   = (end_q >= AW'(scfl_pkg::PoolLimit));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // head memory ports
  always_comb begin
    h_raddr = cmd_i.rem_rd ? rem_cls : (cmd_i.free_rd ? fcls : acls);
    h_we    = cmd_i.clr | cmd_i.free_wr | cmd_i.pop | cmd_i.carve_end | cmd_i.rem_wr;
    if (cmd_i.clr) h_waddr = clr_idx_q;
    else if (cmd_i.rem_wr) h_waddr = rem_cls;
    else if (cmd_i.free_wr) h_waddr = fcls;
    else h_waddr = acls;
    if (cmd_i.clr) h_wdata = '0;
    else if (cmd_i.free_wr) h_wdata = addr_q;
    else if (cmd_i.pop) h_wdata = l_rdata;
    else if (cmd_i.carve_end) h_wdata = hd_q;
    else h_wdata = cur_q;
  end

  // link memory ports
  always_comb begin
    l_we    = cmd_i.free_wr | cmd_i.carve | cmd_i.rem_wr;
    l_waddr = cmd_i.free_wr ? scfl_pkg::LinkAw'(addr_q - AW'(1))
                            : scfl_pkg::LinkAw'(cur_q - AW'(1));
    l_wdata = cmd_i.carve ? hd_q : h_rdata;
    l_raddr = scfl_pkg::LinkAw'(h_rdata - AW'(1));
  end

  always_comb begin
    cur_d = cur_q;
    end_d = end_q;
    if (cmd_i.carve) begin
      cur_d = cur_q + blk_z;
    end else if (cmd_i.next_chunk) begin
      cur_d = end_q;
      if (!sts_o.pool_out) begin
        end_d = (nsum > (AW+1)'(scfl_pkg::PoolLimit)) ? AW'(scfl_pkg::PoolLimit)
                                                      : nsum[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= AW'(1);
      end_q       <= AW'(scfl_pkg::EndInit);
      clr_idx_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q <= cur_d;
      end_q <= end_d;
      if (cmd_i.clr) clr_idx_q <= clr_idx_q + CW'(1);
      if (cmd_i.alloc_hd) cnt_q <= '0;
      else if (cmd_i.carve) cnt_q <= cnt_q + scfl_pkg::CntW'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q      <= in_mode_i;
      size_q      <= in_size_i;
      prev_size_q <= in_prev_size_i;
      addr_q      <= in_address_i;
    end
    if (cmd_i.alloc_hd) hd_q <= h_rdata;
    else if (cmd_i.carve) hd_q <= cur_q;
    if (cmd_i.set_res) begin
      res_st_q <= cmd_i.res_code;
      case (cmd_i.res_src)
        scfl_pkg::SRC_HEAD:   res_blk_q <= hd_q;
        scfl_pkg::SRC_CURSOR: res_blk_q <= cur_q;
        default:              res_blk_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_st_q  <= res_st_q;
      out_blk_q <= res_blk_q;
    end
  end

  scfl_ram #(.Width(AW), .Depth(scfl_pkg::NumClasses)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  scfl_ram #(.Width(AW), .Depth(scfl_pkg::MemUnits)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_block_o  = out_blk_q;

endmodule
`default_nettype wire

// ===== src/size_class_free_list_allocator_top.sv =====
// Size-class free-list allocator: 512 classes of 8-byte multiples over a 64K-unit pool.
// One request at a time. After reset the class head memory is cleared with tready
// low. A free reads and then writes the class head; an allocate that pops a cached
// block reads its class head, then the link memory; a reallocate adds the free steps
// first. An allocate that refills carves one block per cycle (up to 10), and each
// chunk switch first pushes any remainder onto its class list. The class head
// memory and the link memory each have one read and one write port with a registered read.
`default_nettype none
module size_class_free_list_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // size[15:0], prev_size[31:16], address[48:32]
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // block_address[16:0]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  scfl_pkg::cmd_t cmd;
  scfl_pkg::sts_t sts;
  logic [scfl_pkg::AddrW-1:0] blk;

  scfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scfl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_mode_i      (s_axis_tuser),
    .in_size_i      (s_axis_tdata[15:0]),
    .in_prev_size_i (s_axis_tdata[31:16]),
    .in_address_i   (s_axis_tdata[48:32]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (m_axis_tuser),
    .out_block_o    (blk)
  );

  assign s_axis_tready = cmd.ready;
  assign m_axis_tdata  = {7'd0, blk};

endmodule
`default_nettype wire
